// File: src/tube_light_box_bounds_accumulator_defines.svh
// Assertion macros for the tube light box bounds accumulator.
// Used by the port checker; expects i_clk and i_rst_n in scope.
`ifndef TUBE_LIGHT_BOX_BOUNDS_ACCUMULATOR_DEFINES_SVH
`define TUBE_LIGHT_BOX_BOUNDS_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define TLBBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define TLBBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/tlbba_pkg.sv
// Shared types, widths and codes of the tube light box bounds accumulator.
// No dependencies.
package tlbba_pkg;

    // Default parameter values
    localparam int DEF_FRAC_BITS   = 16;
    localparam int DEF_COORD_WIDTH = 32;

    // Fixed field widths
    localparam int OP_W      = 2;
    localparam int ROW_W     = 2;
    localparam int COEF_W    = 32;
    localparam int OUT_W     = 32;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;

    // Local corner coordinates never exceed 2^32 in magnitude
    localparam int LCL_W  = 33;
    localparam int PROD_W = COEF_W + LCL_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int EXT_W  = SUM_W + 1;

    // Matrix shape and corner walk
    localparam int MAT_ROWS    = 3;
    localparam int MAT_COLS    = 4;
    localparam int CORNER_W    = 3;
    localparam logic [CORNER_W-1:0] CORNER_LAST = 3'd7;

    // Queue depths
    localparam int CMDQ_DEPTH = 4;
    localparam int RESQ_DEPTH = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_TRANS = 2'd2;
    localparam logic [OP_W-1:0] OP_PLAIN = 2'd3;

    // Row code that selects no matrix row
    localparam logic [ROW_W-1:0] ROW_NONE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TUBE   = 2'd2;

    // Classified command passed from front to back
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [ROW_W-1:0]         row;
        logic                     wr;
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
        logic signed [COEF_W-1:0] coef_offset;
    } t_cmd;

    // Control token travelling beside the arithmetic pipeline
    typedef struct packed {
        logic            vld;
        logic [OP_W-1:0] op;
        logic            last;
    } t_tok;

    // Running box as reported
    typedef struct packed {
        logic signed [OUT_W-1:0] min_x;
        logic signed [OUT_W-1:0] max_x;
        logic signed [OUT_W-1:0] min_y;
        logic signed [OUT_W-1:0] max_y;
        logic signed [OUT_W-1:0] min_z;
        logic signed [OUT_W-1:0] max_z;
    } t_result;

endpackage

// File: src/tlbba_fifo.sv
// Small register-based FIFO used for the command and result queues.
// Depends on nothing but its parameters.
module tlbba_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_pop   = i_pop && !o_empty;
    assign w_push  = i_push && (!o_full || w_pop);
    assign o_data  = r_mem[r_rp];

    // Track occupancy
    always_comb begin
        unique case ({w_push, w_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
        end
    end

    // Store item
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: src/tlbba_front.sv
// Front end: accepts items, classifies them into commands and queues them.
// Depends on tlbba_pkg and tlbba_fifo.
module tlbba_front import tlbba_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic [OP_W-1:0]          i_op,
    input  logic [ROW_W-1:0]         i_row_index,
    input  logic signed [COEF_W-1:0] i_coef_a,
    input  logic signed [COEF_W-1:0] i_coef_b,
    input  logic signed [COEF_W-1:0] i_coef_c,
    input  logic signed [COEF_W-1:0] i_coef_offset,
    output logic                     o_cmd_vld,
    output t_cmd                     o_cmd,
    input  logic                     i_cmd_pop
);

    t_cmd w_cmd;
    logic w_empty;

    // Classify: a load to the unused row writes nothing
    always_comb begin
        w_cmd.op          = i_op;
        w_cmd.row         = i_row_index;
        w_cmd.wr          = (i_op == OP_LOAD) && (i_row_index != ROW_NONE);
        w_cmd.coef_a      = i_coef_a;
        w_cmd.coef_b      = i_coef_b;
        w_cmd.coef_c      = i_coef_c;
        w_cmd.coef_offset = i_coef_offset;
    end

    tlbba_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !o_full),
        .i_data  (w_cmd),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_full  (o_full),
        .o_empty (w_empty)
    );

    assign o_cmd_vld = !w_empty;

endmodule

// File: src/tlbba_row_unit.sv
// One matrix row applied to a local corner: three multipliers, exact sum,
// floor by the fraction bits, offset add and saturation. Depends on tlbba_pkg.
module tlbba_row_unit import tlbba_pkg::*; #(
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COEF_W-1:0]      i_coef_a,
    input  logic signed [COEF_W-1:0]      i_coef_b,
    input  logic signed [COEF_W-1:0]      i_coef_c,
    input  logic signed [COEF_W-1:0]      i_coef_offset,
    input  logic signed [LCL_W-1:0]       i_x,
    input  logic signed [LCL_W-1:0]       i_y,
    input  logic signed [LCL_W-1:0]       i_z,
    output logic signed [COORD_WIDTH-1:0] o_res
);

    localparam logic signed [EXT_W-1:0] X_MAX = EXT_W'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    localparam logic signed [EXT_W-1:0] X_MIN = ~X_MAX;

    logic signed [PROD_W-1:0]      w_pa, w_pb, w_pc;
    logic signed [PROD_W-1:0]      r_pa, r_pb, r_pc;
    logic signed [COEF_W-1:0]      r_off1, r_off2;
    logic signed [SUM_W-1:0]       r_sum;
    logic signed [SUM_W-1:0]       w_floor;
    logic signed [EXT_W-1:0]       w_total;
    logic signed [EXT_W-1:0]       w_sat;
    logic signed [COORD_WIDTH-1:0] r_res;

    assign w_pa = PROD_W'(i_coef_a) * PROD_W'(i_x);
    assign w_pb = PROD_W'(i_coef_b) * PROD_W'(i_y);
    assign w_pc = PROD_W'(i_coef_c) * PROD_W'(i_z);

    // Round the exact sum once toward minus infinity, then add the offset
    assign w_floor = r_sum >>> FRAC_BITS;
    assign w_total = EXT_W'(w_floor) + EXT_W'(r_off2);

    // Clamp to the coordinate range
    always_comb begin
        priority if (w_total > X_MAX) begin
            w_sat = X_MAX;
        end else if (w_total < X_MIN) begin
            w_sat = X_MIN;
        end else begin
            w_sat = w_total;
        end
    end

    // Multiply, sum, round and clamp stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa   <= w_pa;
            r_pb   <= w_pb;
            r_pc   <= w_pc;
            r_off1 <= i_coef_offset;
            r_sum  <= SUM_W'(r_pa) + SUM_W'(r_pb) + SUM_W'(r_pc);
            r_off2 <= r_off1;
            r_res  <= w_sat[COORD_WIDTH-1:0];
        end
    end

    assign o_res = r_res;

endmodule

// File: src/tlbba_back.sv
// Back end: walks the box corners, runs the three row units, widens the
// running box and queues results. Depends on tlbba_pkg, tlbba_row_unit, tlbba_fifo.
module tlbba_back import tlbba_pkg::*; #(
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_vld,
    input  t_cmd             i_cmd,
    output logic             o_cmd_pop,
    input  logic [CFG_W-1:0] i_radius,
    input  logic [CFG_W-1:0] i_fall_distance,
    input  logic [CFG_W-1:0] i_tube_length,
    input  logic             i_pop,
    output logic             o_empty,
    output t_result          o_res
);

    localparam logic signed [EXT_W-1:0] X_MAX = EXT_W'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    localparam logic signed [EXT_W-1:0] X_MIN = ~X_MAX;
    localparam logic signed [COORD_WIDTH-1:0] B_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] B_MIN = ~B_MAX;

    function automatic logic signed [EXT_W-1:0] sat_ext(input logic signed [EXT_W-1:0] v);
        if (v > X_MAX) begin
            return X_MAX;
        end else if (v < X_MIN) begin
            return X_MIN;
        end
        return v;
    endfunction

    logic signed [EXT_W-1:0]       w_r, w_zlo, w_zhi;
    logic signed [LCL_W-1:0]       w_r_l;
    logic signed [COORD_WIDTH-1:0] w_plain_lo [MAT_ROWS];
    logic signed [COORD_WIDTH-1:0] w_plain_hi [MAT_ROWS];
    logic signed [COEF_W-1:0]      r_mat [MAT_ROWS][MAT_COLS];
    logic [CORNER_W-1:0]           r_cnt;
    logic signed [LCL_W-1:0]       r_x, r_y, r_z;
    t_tok                          r_s0, r_s1, r_s2, r_s3;
    logic signed [COORD_WIDTH-1:0] w_rowres [MAT_ROWS];
    logic signed [COORD_WIDTH-1:0] r_lo [MAT_ROWS];
    logic signed [COORD_WIDTH-1:0] r_hi [MAT_ROWS];
    logic signed [COORD_WIDTH-1:0] n_lo [MAT_ROWS];
    logic signed [COORD_WIDTH-1:0] n_hi [MAT_ROWS];
    logic signed [COORD_WIDTH-1:0] w_cand_lo [MAT_ROWS];
    logic signed [COORD_WIDTH-1:0] w_cand_hi [MAT_ROWS];
    logic                          w_oq_full;
    logic                          w_adv;
    logic                          w_issue;
    logic                          w_trans;
    logic                          w_last;
    logic                          w_res_push;
    t_result                       w_res;

    // Saturated local box extents
    assign w_r   = sat_ext(EXT_W'({1'b0, i_radius}));
    assign w_zlo = sat_ext(-EXT_W'({1'b0, i_fall_distance}));
    assign w_zhi = sat_ext(EXT_W'({1'b0, i_tube_length}) + EXT_W'({1'b0, i_fall_distance}));
    assign w_r_l = w_r[LCL_W-1:0];

    assign w_plain_lo[0] = -w_r[COORD_WIDTH-1:0];
    assign w_plain_hi[0] = w_r[COORD_WIDTH-1:0];
    assign w_plain_lo[1] = -w_r[COORD_WIDTH-1:0];
    assign w_plain_hi[1] = w_r[COORD_WIDTH-1:0];
    assign w_plain_lo[2] = w_zlo[COORD_WIDTH-1:0];
    assign w_plain_hi[2] = w_zhi[COORD_WIDTH-1:0];

    // Whole pipeline moves when the result queue can take an item
    assign w_adv     = !w_oq_full || i_pop;
    assign w_issue   = w_adv && i_cmd_vld;
    assign w_trans   = (i_cmd.op == OP_TRANS);
    assign w_last    = !w_trans || (r_cnt == CORNER_LAST);
    assign o_cmd_pop = w_issue && w_last;

    // Issue tokens and walk the eight corners
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_s0  <= '0;
            r_s1  <= '0;
            r_s2  <= '0;
            r_s3  <= '0;
        end else if (w_adv) begin
            r_s0.vld  <= w_issue;
            r_s0.op   <= i_cmd.op;
            r_s0.last <= w_last;
            r_s1      <= r_s0;
            r_s2      <= r_s1;
            r_s3      <= r_s2;
            if (w_issue && w_trans) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Latch the corner coordinates
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_x <= r_cnt[0] ? w_r_l : -w_r_l;
            r_y <= r_cnt[1] ? w_r_l : -w_r_l;
            r_z <= r_cnt[2] ? w_zhi[LCL_W-1:0] : w_zlo[LCL_W-1:0];
        end
    end

    // Load a matrix row at issue, in order with the corners
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= '{default: '0};
        end else if (w_issue && (i_cmd.op == OP_LOAD) && i_cmd.wr) begin
            r_mat[i_cmd.row] <= '{i_cmd.coef_a, i_cmd.coef_b, i_cmd.coef_c,
                                  i_cmd.coef_offset};
        end
    end

    for (genvar k = 0; k < MAT_ROWS; k++) begin : g_row
        tlbba_row_unit #(
            .FRAC_BITS   (FRAC_BITS),
            .COORD_WIDTH (COORD_WIDTH)
        ) u_row (
            .i_clk         (i_clk),
            .i_en          (w_adv),
            .i_coef_a      (r_mat[k][0]),
            .i_coef_b      (r_mat[k][1]),
            .i_coef_c      (r_mat[k][2]),
            .i_coef_offset (r_mat[k][3]),
            .i_x           (r_x),
            .i_y           (r_y),
            .i_z           (r_z),
            .o_res         (w_rowres[k])
        );
    end

    // Widen, clear or hold the running box
    always_comb begin
        for (int a = 0; a < MAT_ROWS; a++) begin
            w_cand_lo[a] = (r_s3.op == OP_TRANS) ? w_rowres[a] : w_plain_lo[a];
            w_cand_hi[a] = (r_s3.op == OP_TRANS) ? w_rowres[a] : w_plain_hi[a];
            n_lo[a]      = r_lo[a];
            n_hi[a]      = r_hi[a];
            if (r_s3.vld) begin
                unique case (r_s3.op)
                    OP_CLEAR: begin
                        n_lo[a] = B_MAX;
                        n_hi[a] = B_MIN;
                    end
                    OP_TRANS, OP_PLAIN: begin
                        if (w_cand_lo[a] < r_lo[a]) begin
                            n_lo[a] = w_cand_lo[a];
                        end
                        if (w_cand_hi[a] > r_hi[a]) begin
                            n_hi[a] = w_cand_hi[a];
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= '{default: B_MAX};
            r_hi <= '{default: B_MIN};
        end else if (w_adv) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

    // Report the box after the item's last step
    assign w_res_push  = w_adv && r_s3.vld && r_s3.last;
    assign w_res.min_x = OUT_W'(EXT_W'(n_lo[0]));
    assign w_res.max_x = OUT_W'(EXT_W'(n_hi[0]));
    assign w_res.min_y = OUT_W'(EXT_W'(n_lo[1]));
    assign w_res.max_y = OUT_W'(EXT_W'(n_hi[1]));
    assign w_res.min_z = OUT_W'(EXT_W'(n_lo[2]));
    assign w_res.max_z = OUT_W'(EXT_W'(n_hi[2]));

    tlbba_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RESQ_DEPTH)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .i_pop   (i_pop),
        .o_data  (o_res),
        .o_full  (w_oq_full),
        .o_empty (o_empty)
    );

endmodule

// File: src/tube_light_box_bounds_accumulator.sv
// Path: command queue, corner issue, multiply, sum, clamp, result queue.
// Throughput: one item per cycle while the result queue can take an item,
// except transformed accumulate, which issues one corner per cycle, its eight
// corners sharing the nine multipliers of the three row units.
// Reset (synchronous, i_rst_n low): queues empty, matrix zero, box empty,
// configuration registers zero.
module tube_light_box_bounds_accumulator import tlbba_pkg::*; #(
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_wdata,
    input  logic                     push,
    output logic                     full,
    input  logic [OP_W-1:0]          i_op,
    input  logic [ROW_W-1:0]         i_row_index,
    input  logic signed [COEF_W-1:0] i_coef_a,
    input  logic signed [COEF_W-1:0] i_coef_b,
    input  logic signed [COEF_W-1:0] i_coef_c,
    input  logic signed [COEF_W-1:0] i_coef_offset,
    output logic                     empty,
    input  logic                     pop,
    output logic signed [OUT_W-1:0]  o_min_x,
    output logic signed [OUT_W-1:0]  o_max_x,
    output logic signed [OUT_W-1:0]  o_min_y,
    output logic signed [OUT_W-1:0]  o_max_y,
    output logic signed [OUT_W-1:0]  o_min_z,
    output logic signed [OUT_W-1:0]  o_max_z
);

    logic [CFG_W-1:0] r_radius;
    logic [CFG_W-1:0] r_fall_distance;
    logic [CFG_W-1:0] r_tube_length;
    logic             w_cmd_vld;
    logic             w_cmd_pop;
    t_cmd             w_cmd;
    t_result          w_res;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius        <= '0;
            r_fall_distance <= '0;
            r_tube_length   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RADIUS: r_radius        <= i_cfg_wdata;
                REG_FALL:   r_fall_distance <= i_cfg_wdata;
                REG_TUBE:   r_tube_length   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    tlbba_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_op          (i_op),
        .i_row_index   (i_row_index),
        .i_coef_a      (i_coef_a),
        .i_coef_b      (i_coef_b),
        .i_coef_c      (i_coef_c),
        .i_coef_offset (i_coef_offset),
        .o_cmd_vld     (w_cmd_vld),
        .o_cmd         (w_cmd),
        .i_cmd_pop     (w_cmd_pop)
    );

    tlbba_back #(
        .FRAC_BITS   (FRAC_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_vld       (w_cmd_vld),
        .i_cmd           (w_cmd),
        .o_cmd_pop       (w_cmd_pop),
        .i_radius        (r_radius),
        .i_fall_distance (r_fall_distance),
        .i_tube_length   (r_tube_length),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_res           (w_res)
    );

    assign o_min_x = w_res.min_x;
    assign o_max_x = w_res.max_x;
    assign o_min_y = w_res.min_y;
    assign o_max_y = w_res.max_y;
    assign o_min_z = w_res.min_z;
    assign o_max_z = w_res.max_z;

endmodule

// File: src/tlbba_checker.sv
// Port-level checks of the tube light box bounds accumulator, bound to the top.
// Depends on tlbba_pkg and tube_light_box_bounds_accumulator_defines.svh.
`include "tube_light_box_bounds_accumulator_defines.svh"

module tlbba_checker import tlbba_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    push,
    input logic                    full,
    input logic                    empty,
    input logic                    pop,
    input logic signed [OUT_W-1:0] o_min_x,
    input logic signed [OUT_W-1:0] o_max_x,
    input logic signed [OUT_W-1:0] o_min_y,
    input logic signed [OUT_W-1:0] o_max_y,
    input logic signed [OUT_W-1:0] o_min_z,
    input logic signed [OUT_W-1:0] o_max_z
);

    // Both queues come out of reset empty
    `TLBBA_ASSERT_NOW(a_reset_idle, $past(!i_rst_n), empty && !full, "queues not empty after reset")

    // Command queue fills only through accepted items
    `TLBBA_ASSERT_NEXT(a_full_needs_push, !full && !push, !full, "full rose without a push")

    // Hold a waiting result until it is taken
    `TLBBA_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(o_min_x) && $stable(o_max_x) && $stable(o_min_y) && $stable(o_max_y) && $stable(o_min_z) && $stable(o_max_z), "waiting result changed")

endmodule

bind tube_light_box_bounds_accumulator tlbba_checker u_tlbba_checker (.*);

// File: tb/tube_light_box_bounds_accumulator_tb.sv
// Self-checking testbench for the tube light box bounds accumulator.
// Drives directed and random items through the push/full queue port, predicts
// each running box in a local model and checks it on the pop side. Needs tlbba_pkg.
`timescale 1ns / 1ps

module tube_light_box_bounds_accumulator_tb;
    import tlbba_pkg::*;

    typedef logic signed [79:0] t_coord_wide;

    // One row of stimulus: either a register set-up or an item,
    // optionally with its box typed in
    typedef struct packed {
        bit                       is_cfg;
        logic [CFG_W-1:0]         radius;
        logic [CFG_W-1:0]         fall;
        logic [CFG_W-1:0]         tube;
        logic [OP_W-1:0]          op;
        logic [ROW_W-1:0]         row;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] off;
        bit                       typed;
        t_result                  box;
    } t_light_row;

    localparam logic signed [OUT_W-1:0] BOX_HI   = 32'sh7FFF_FFFF;
    localparam logic signed [OUT_W-1:0] BOX_LO   = 32'sh8000_0000;
    localparam logic signed [OUT_W-1:0] BOX_NEG  = 32'sh8000_0001;
    localparam t_coord_wide             WIDE_HI  = 80'sh7FFF_FFFF;
    localparam t_coord_wide             WIDE_LO  = -80'sh8000_0000;
    localparam logic [CFG_W-1:0]        CFG_TOP  = 31'h7FFF_FFFF;
    localparam t_result EMPTY_BOX = '{BOX_HI, BOX_LO, BOX_HI, BOX_LO, BOX_HI, BOX_LO};
    localparam t_result ZERO_BOX  = '{0, 0, 0, 0, 0, 0};
    localparam t_result FULL_BOX  = '{BOX_NEG, BOX_HI, BOX_NEG, BOX_HI, BOX_NEG, BOX_HI};
    localparam int      QUIET_LIMIT = 5000;
    localparam int      LONG_HOLD   = 400;
    localparam int      DRAIN_WAIT  = 40;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_idx;
    logic [CFG_W-1:0]         i_cfg_wdata;
    logic                     push;
    logic                     full;
    logic [OP_W-1:0]          i_op;
    logic [ROW_W-1:0]         i_row_index;
    logic signed [COEF_W-1:0] i_coef_a;
    logic signed [COEF_W-1:0] i_coef_b;
    logic signed [COEF_W-1:0] i_coef_c;
    logic signed [COEF_W-1:0] i_coef_offset;
    logic                     empty;
    logic                     pop;
    logic signed [OUT_W-1:0]  o_min_x;
    logic signed [OUT_W-1:0]  o_max_x;
    logic signed [OUT_W-1:0]  o_min_y;
    logic signed [OUT_W-1:0]  o_max_y;
    logic signed [OUT_W-1:0]  o_min_z;
    logic signed [OUT_W-1:0]  o_max_z;

    // Typed-in box travelling beside the item being offered
    bit      tag_typed;
    t_result tag_box;

    // Model state: matrix, running box and register copies
    t_coord_wide             light_mat [MAT_ROWS*MAT_COLS];
    logic signed [OUT_W-1:0] box_lim [6];
    logic [CFG_W-1:0]        cfg_radius;
    logic [CFG_W-1:0]        cfg_fall;
    logic [CFG_W-1:0]        cfg_tube;

    t_result    pending_boxes [$];
    int         mismatches;
    int         quiet_cycles;
    int         items_sent;
    bit         hold_req;
    bit         sender_burst;

    tube_light_box_bounds_accumulator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .push          (push),
        .full          (full),
        .i_op          (i_op),
        .i_row_index   (i_row_index),
        .i_coef_a      (i_coef_a),
        .i_coef_b      (i_coef_b),
        .i_coef_c      (i_coef_c),
        .i_coef_offset (i_coef_offset),
        .empty         (empty),
        .pop           (pop),
        .o_min_x       (o_min_x),
        .o_max_x       (o_max_x),
        .o_min_y       (o_min_y),
        .o_max_y       (o_max_y),
        .o_min_z       (o_min_z),
        .o_max_z       (o_max_z)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- model

    function automatic t_coord_wide clamp_coord(t_coord_wide v);
        if (v > WIDE_HI) return WIDE_HI;
        if (v < WIDE_LO) return WIDE_LO;
        return v;
    endfunction

    // Exact row sum, one floor by the fraction bits, add offset, saturate
    function automatic t_coord_wide row_eval(int row, t_coord_wide x, t_coord_wide y,
                                             t_coord_wide z);
        t_coord_wide acc;
        acc = light_mat[row*MAT_COLS] * x + light_mat[row*MAT_COLS+1] * y
            + light_mat[row*MAT_COLS+2] * z;
        acc = acc >>> DEF_FRAC_BITS;
        return clamp_coord(acc + light_mat[row*MAT_COLS+3]);
    endfunction

    function automatic void widen_axis(int axis, t_coord_wide v);
        if (v < box_lim[2*axis])   box_lim[2*axis]   = v[OUT_W-1:0];
        if (v > box_lim[2*axis+1]) box_lim[2*axis+1] = v[OUT_W-1:0];
    endfunction

    function automatic void empty_box();
        for (int k = 0; k < 3; k++) begin
            box_lim[2*k]   = BOX_HI;
            box_lim[2*k+1] = BOX_LO;
        end
    endfunction

    function automatic void reset_light_model();
        for (int k = 0; k < MAT_ROWS*MAT_COLS; k++) light_mat[k] = '0;
        empty_box();
        cfg_radius = '0;
        cfg_fall   = '0;
        cfg_tube   = '0;
    endfunction

    // Apply one item to the model and return the running box after it
    function automatic t_result step_light(logic [OP_W-1:0] op, logic [ROW_W-1:0] row,
                                           logic signed [COEF_W-1:0] a,
                                           logic signed [COEF_W-1:0] b,
                                           logic signed [COEF_W-1:0] c,
                                           logic signed [COEF_W-1:0] off);
        t_coord_wide r;
        t_coord_wide zlo;
        t_coord_wide zhi;
        t_coord_wide x;
        t_coord_wide y;
        t_coord_wide z;
        t_result     res;
        r   = clamp_coord($signed({49'd0, cfg_radius}));
        zlo = clamp_coord(-$signed({49'd0, cfg_fall}));
        zhi = clamp_coord($signed({49'd0, cfg_tube}) + $signed({49'd0, cfg_fall}));
        case (op)
            OP_LOAD: begin
                if (row != ROW_NONE) begin
                    light_mat[row*MAT_COLS]   = t_coord_wide'(a);
                    light_mat[row*MAT_COLS+1] = t_coord_wide'(b);
                    light_mat[row*MAT_COLS+2] = t_coord_wide'(c);
                    light_mat[row*MAT_COLS+3] = t_coord_wide'(off);
                end
            end
            OP_CLEAR: begin
                empty_box();
            end
            OP_TRANS: begin
                for (int k = 0; k < 8; k++) begin
                    x = k[0] ? r : -r;
                    y = k[1] ? r : -r;
                    z = k[2] ? zhi : zlo;
                    for (int ax = 0; ax < MAT_ROWS; ax++) widen_axis(ax, row_eval(ax, x, y, z));
                end
            end
            default: begin
                widen_axis(0, -r);
                widen_axis(0, r);
                widen_axis(1, -r);
                widen_axis(1, r);
                widen_axis(2, zlo);
                widen_axis(2, zhi);
            end
        endcase
        res.min_x = box_lim[0];
        res.max_x = box_lim[1];
        res.min_y = box_lim[2];
        res.max_y = box_lim[3];
        res.min_z = box_lim[4];
        res.max_z = box_lim[5];
        return res;
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void check_field(string name, logic signed [OUT_W-1:0] want,
                                        logic signed [OUT_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Predict on every accepted item, check every popped box, watch for a hang
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            reset_light_model();
            quiet_cycles = 0;
        end else begin
            if (pop && !empty) begin
                if (pending_boxes.size() == 0) begin
                    $error("box popped with none expected");
                    mismatches++;
                end else begin
                    want = pending_boxes.pop_front();
                    check_field("min_x", want.min_x, o_min_x);
                    check_field("max_x", want.max_x, o_max_x);
                    check_field("min_y", want.min_y, o_min_y);
                    check_field("max_y", want.max_y, o_max_y);
                    check_field("min_z", want.min_z, o_min_z);
                    check_field("max_z", want.max_z, o_max_z);
                end
            end
            if (push && !full) begin
                want = step_light(i_op, i_row_index, i_coef_a, i_coef_b, i_coef_c,
                                  i_coef_offset);
                if (tag_typed) want = tag_box;
                pending_boxes.push_back(want);
            end
            if ((push && !full) || (pop && !empty) || i_cfg_we) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[tube_light_box_bounds_accumulator] ERROR");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    // Mostly no gap, sometimes short, rarely long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coef();
        int p;
        p = $urandom_range(0, 9);
        if (p < 5) return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        if (p < 8) return $urandom;
        case ($urandom_range(0, 4))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            3:       return 32'sh0001_0000;
            default: return -32'sh0001_0000;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_cfg();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return '0;
        if (p == 1) return CFG_TOP;
        if (p < 7)  return CFG_W'($urandom_range(0, 32'h00FF_FFFF));
        return CFG_W'($urandom);
    endfunction

    function automatic t_light_row mk_item(logic [OP_W-1:0] op, logic [ROW_W-1:0] row,
                                           logic signed [COEF_W-1:0] a,
                                           logic signed [COEF_W-1:0] b,
                                           logic signed [COEF_W-1:0] c,
                                           logic signed [COEF_W-1:0] off);
        t_light_row it;
        it     = '0;
        it.op  = op;
        it.row = row;
        it.a   = a;
        it.b   = b;
        it.c   = c;
        it.off = off;
        return it;
    endfunction

    function automatic t_light_row mk_typed(logic [OP_W-1:0] op, t_result box);
        t_light_row it;
        it       = mk_item(op, '0, 32'sh5A5A_5A5A, -32'sh1234_5678, 32'sh0F0F_0F0F, '1);
        it.typed = 1'b1;
        it.box   = box;
        return it;
    endfunction

    function automatic t_light_row mk_cfg(logic [CFG_W-1:0] r, logic [CFG_W-1:0] f,
                                          logic [CFG_W-1:0] t);
        t_light_row it;
        it        = '0;
        it.is_cfg = 1'b1;
        it.radius = r;
        it.fall   = f;
        it.tube   = t;
        return it;
    endfunction

    function automatic t_light_row mk_rand(logic [OP_W-1:0] op, logic [ROW_W-1:0] row);
        return mk_item(op, row, rand_coef(), rand_coef(), rand_coef(), rand_coef());
    endfunction

    // Offer one item until it is taken, then idle for a random gap unless in burst mode
    task automatic send_item(t_light_row it);
        int gap;
        i_op          <= it.op;
        i_row_index   <= it.row;
        i_coef_a      <= it.a;
        i_coef_b      <= it.b;
        i_coef_c      <= it.c;
        i_coef_offset <= it.off;
        tag_typed     <= it.typed;
        tag_box       <= it.box;
        push          <= 1'b1;
        do @(posedge i_clk); while (full);
        items_sent++;
        gap = sender_burst ? 0 : pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every box is back and the block is quiet
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_boxes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Write all three registers while the block is idle
    task automatic program_regs(logic [CFG_W-1:0] r, logic [CFG_W-1:0] f,
                                logic [CFG_W-1:0] t);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_RADIUS;
        i_cfg_wdata <= r;
        @(posedge i_clk);
        cfg_radius  = r;
        i_cfg_idx   <= REG_FALL;
        i_cfg_wdata <= f;
        @(posedge i_clk);
        cfg_fall    = f;
        i_cfg_idx   <= REG_TUBE;
        i_cfg_wdata <= t;
        @(posedge i_clk);
        cfg_tube    = t;
        i_cfg_we    <= 1'b0;
    endtask

    // Receiver: random pops, steady stretches, and one long hold on request
    initial begin
        int stall_left;
        int mode_left;
        bit steady;
        pop        = 1'b0;
        stall_left = 0;
        mode_left  = 0;
        steady     = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                steady    = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(50, 300);
            end else begin
                mode_left--;
            end
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= 1'b1;
                if (!steady) stall_left = pick_gap();
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain, verdict
    initial begin
        t_light_row directed [$];
        t_light_row it;
        int         phase_start;
        int         n_acc;
        bit         hold_done;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_wdata   = '0;
        push          = 1'b0;
        i_op          = '0;
        i_row_index   = '0;
        i_coef_a      = '0;
        i_coef_b      = '0;
        i_coef_c      = '0;
        i_coef_offset = '0;
        tag_typed     = 1'b0;
        tag_box       = '0;
        mismatches    = 0;
        items_sent    = 0;
        hold_req      = 1'b0;
        sender_burst  = 1'b0;
        hold_done     = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers at reset value: zero-size box, zero matrix
        directed.push_back(mk_typed(OP_CLEAR, EMPTY_BOX));
        directed.push_back(mk_typed(OP_PLAIN, ZERO_BOX));
        directed.push_back(mk_typed(OP_TRANS, ZERO_BOX));
        // Largest registers: far corner saturates
        directed.push_back(mk_cfg(CFG_TOP, CFG_TOP, CFG_TOP));
        directed.push_back(mk_typed(OP_CLEAR, EMPTY_BOX));
        directed.push_back(mk_typed(OP_PLAIN, FULL_BOX));
        directed.push_back(mk_item(OP_LOAD, 2'd0, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                   32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        directed.push_back(mk_item(OP_LOAD, 2'd1, 32'sh8000_0000, 32'sh7FFF_FFFF,
                                   32'sh8000_0000, 32'sh8000_0000));
        directed.push_back(mk_item(OP_LOAD, 2'd2, 32'sh0001_0000, 32'sh0000_0000,
                                   -32'sh0000_8000, -32'sh0000_0001));
        // Load of the unused row must change nothing
        directed.push_back(mk_item(OP_LOAD, ROW_NONE, 32'sh1234_5678, -32'sh0765_4321,
                                   32'sh7FFF_0000, 32'sh8000_FFFF));
        directed.push_back(mk_typed(OP_CLEAR, EMPTY_BOX));
        directed.push_back(mk_item(OP_TRANS, ROW_NONE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                   32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        directed.push_back(mk_item(OP_PLAIN, 2'd2, 32'sh8000_0000, 32'sh8000_0000,
                                   32'sh8000_0000, 32'sh8000_0000));
        // Half and odd fractions: exercise the single floor of the row sum
        directed.push_back(mk_cfg(31'h0001_8001, 31'h0000_0000, 31'h0003_0000));
        directed.push_back(mk_item(OP_LOAD, 2'd0, 32'sh0000_8000, -32'sh0000_8000,
                                   32'sh0000_0001, 32'sh0000_0000));
        directed.push_back(mk_item(OP_LOAD, 2'd1, 32'sh0000_0000, 32'sh0001_0000,
                                   -32'sh0000_0003, 32'sh0000_0007));
        directed.push_back(mk_item(OP_LOAD, 2'd2, -32'sh0000_4001, 32'sh0000_0000,
                                   32'sh0001_0000, -32'sh0000_0001));
        directed.push_back(mk_typed(OP_CLEAR, EMPTY_BOX));
        directed.push_back(mk_item(OP_TRANS, 2'd0, 0, 0, 0, 0));
        directed.push_back(mk_item(OP_PLAIN, 2'd0, 0, 0, 0, 0));
        // Zero radius, largest falloff, no tube
        directed.push_back(mk_cfg(31'h0000_0000, CFG_TOP, 31'h0000_0000));
        directed.push_back(mk_typed(OP_CLEAR, EMPTY_BOX));
        directed.push_back(mk_item(OP_TRANS, 2'd0, 0, 0, 0, 0));
        directed.push_back(mk_item(OP_PLAIN, 2'd0, 0, 0, 0, 0));

        foreach (directed[k]) begin
            if (directed[k].is_cfg) begin
                drain();
                program_regs(directed[k].radius, directed[k].fall, directed[k].tube);
            end else begin
                send_item(directed[k]);
            end
        end

        // Random phases, each with its own register setting
        for (int phase = 0; phase < 6; phase++) begin
            drain();
            if (phase == 5) program_regs(rand_cfg() & 31'h0000_FFFF, '0, CFG_TOP);
            else program_regs(rand_cfg(), rand_cfg(), rand_cfg());
            sender_burst = (phase == 1);
            phase_start  = items_sent;
            while (items_sent - phase_start < 250) begin
                if ($urandom_range(0, 6) == 0) begin
                    // Noise: any op, any row, including the unused one
                    repeat ($urandom_range(1, 4))
                        send_item(mk_rand(OP_W'($urandom_range(0, 3)),
                                          ROW_W'($urandom_range(0, 3))));
                end else begin
                    // Well-formed scene: usually a clear, load rows, then accumulate
                    if ($urandom_range(0, 3) != 0) send_item(mk_rand(OP_CLEAR, 2'd0));
                    for (int r = 0; r < MAT_ROWS; r++) send_item(mk_rand(OP_LOAD, ROW_W'(r)));
                    n_acc = $urandom_range(1, 6);
                    for (int k = 0; k < n_acc; k++) begin
                        if ($urandom_range(0, 5) == 0)
                            send_item(mk_rand(OP_LOAD, ROW_W'($urandom_range(0, 2))));
                        if ($urandom_range(0, 2) != 0) send_item(mk_rand(OP_TRANS, 2'd0));
                        else send_item(mk_rand(OP_PLAIN, 2'd0));
                    end
                end
                // Hold the receiver off once while items keep coming
                if (phase == 1 && !hold_done && items_sent - phase_start >= 40) begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
            end
        end

        drain();
        if (mismatches == 0 && pending_boxes.size() == 0)
            $display("[tube_light_box_bounds_accumulator] OK");
        else
            $display("[tube_light_box_bounds_accumulator] ERROR");
        $finish;
    end

endmodule
